// ----- hdl/cxb_pkg.sv -----
package cxb_pkg;

	localparam int MAX_DIMENSION = 4096;

	// Counter width holds 0..MAX_DIMENSION-1, register width holds MAX_DIMENSION itself
	localparam int CNT_W  = $clog2(MAX_DIMENSION);
	localparam int DIM_W  = 13;
	localparam int OFS_W  = 16;
	localparam int ADDR_W = 26;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int POS_W  = OFS_W + 2;
	localparam int PROD_W = CNT_W + DIM_W;

	localparam logic [IDX_W-1:0] REG_DEST_WIDTH    = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_DEST_HEIGHT   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_OFFSET_X      = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_OFFSET_Y      = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = IDX_W'(5);

	typedef struct packed {
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
	} pos_t;

	// Zero reads as one, anything above the maximum reads as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- hdl/clipped_xrgb_to_rgb24_blit_top.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall   pixel_word, buffer_start
// output    out        out_valid / out_stall byte_address, red, green, blue
// config    in         cfg_write             cfg_index, cfg_data
//
// One pixel per clock sustained unless out_stall backs up; a kept pixel passes through
// the position register, the row multiply register and the result register, in that order.
// Pixels outside the destination frame are dropped in the second stage and give no transaction.
// Reset clears the counters, the stage valids and loads the register defaults.
// An output stall backs up only as far as the first empty stage; in_stall rises when all are full.
module clipped_xrgb_to_rgb24_blit_top import cxb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       pixel_word,
	input  logic              buffer_start,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ADDR_W-1:0] byte_address,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue
);

	logic [DIM_W-1:0] dest_width_q, dest_height_q, source_width_q, source_height_q;
	logic [OFS_W-1:0] offset_x_q, offset_y_q;
	logic [DIM_W-1:0] dw, dh, sw, sh;

	logic             accept;
	pos_t             pos;

	logic             valid_s1;
	pos_t             pos_s1;
	logic [23:0]      rgb_s1;

	logic             valid_s2;
	logic [PROD_W-1:0] row_base_s2;
	logic [CNT_W-1:0] tx_s2;
	logic [23:0]      rgb_s2;

	logic             rdy_s1, rdy_s2, rdy_out;
	logic signed [POS_W-1:0] tx, ty;
	logic             hit;
	logic [PROD_W-1:0] pix_index;
	logic [ADDR_W-1:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q    <= DIM_W'(1024);
			dest_height_q   <= DIM_W'(768);
			offset_x_q      <= '0;
			offset_y_q      <= '0;
			source_width_q  <= DIM_W'(1);
			source_height_q <= DIM_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEST_WIDTH:    dest_width_q    <= cfg_data[DIM_W-1:0];
				REG_DEST_HEIGHT:   dest_height_q   <= cfg_data[DIM_W-1:0];
				REG_OFFSET_X:      offset_x_q      <= cfg_data[OFS_W-1:0];
				REG_OFFSET_Y:      offset_y_q      <= cfg_data[OFS_W-1:0];
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[DIM_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign dw = clamp_dim(dest_width_q);
	assign dh = clamp_dim(dest_height_q);
	assign sw = clamp_dim(source_width_q);
	assign sh = clamp_dim(source_height_q);

	// Each stage moves when the one after it is empty or moving
	assign rdy_out  = !out_valid || !out_stall;
	assign rdy_s2   = !valid_s2 || rdy_out;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept   = in_valid && rdy_s1;

	cxb_position u_position (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.buffer_start (buffer_start),
		.src_w        (sw),
		.src_h        (sh),
		.pos          (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
			rgb_s1 <= pixel_word[23:0];
		end
	end

	assign tx = POS_W'(signed'(offset_x_q)) + signed'(POS_W'(pos_s1.col));
	assign ty = POS_W'(signed'(offset_y_q)) + signed'(POS_W'(pos_s1.row));

	assign hit = !tx[POS_W-1] && (tx[POS_W-2:0] < (POS_W-1)'(dw))
		&& !ty[POS_W-1] && (ty[POS_W-2:0] < (POS_W-1)'(dh));

	// Drop pixels that miss the frame here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			row_base_s2 <= ty[CNT_W-1:0] * dw;
			tx_s2       <= tx[CNT_W-1:0];
			rgb_s2      <= rgb_s1;
		end
	end

	assign pix_index = row_base_s2 + PROD_W'(tx_s2);
	assign addr      = ADDR_W'(pix_index) + {pix_index, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (rdy_out) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s2) begin
			byte_address <= addr;
			red          <= rgb_s2[23:16];
			green        <= rgb_s2[15:8];
			blue         <= rgb_s2[7:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid)
		else $error("input held off with an empty stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_valid && out_stall |=> valid_s2)
		else $error("second stage lost a transaction under output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> DIM_W'(tx_s2) < dw)
		else $error("kept pixel lies outside the destination width");

endmodule

// ----- hdl/cxb_position.sv -----
module cxb_position import cxb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             buffer_start,
	input  logic [DIM_W-1:0] src_w,
	input  logic [DIM_W-1:0] src_h,
	output pos_t             pos
);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;

	// A buffer start places this pixel at the origin
	assign pos.col = buffer_start ? '0 : col_q;
	assign pos.row = buffer_start ? '0 : row_q;

	assign col_inc = DIM_W'(pos.col) + DIM_W'(1);
	assign row_inc = DIM_W'(pos.row) + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_inc >= src_w) begin
				col_q <= '0;
				row_q <= (row_inc >= src_h) ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
				row_q <= pos.row;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && buffer_start && src_w == DIM_W'(1) |=> col_q == '0)
		else $error("column did not wrap on a one-pixel-wide buffer");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import cxb_pkg::*; ();

	// Indexes outside the register map; writes to them must have no effect
	localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(7);

	localparam int BUF_CAP = 48;

	typedef struct packed {
		logic [31:0] word;
		logic        start;
	} pixel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        r;
		logic [7:0]        g;
		logic [7:0]        b;
	} rgb_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [31:0]       pixel_word = '0;
	logic              buffer_start = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ADDR_W-1:0] byte_address;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;

	pixel_t pending_px[$];
	rgb_t   expected_rgb[$];

	bit in_fire = 1'b0;
	bit calm = 1'b0;
	int errors = 0;

	// Shadow copy of the registers and the raster position
	logic [DIM_W-1:0]        sh_dest_w = DIM_W'(1024);
	logic [DIM_W-1:0]        sh_dest_h = DIM_W'(768);
	logic signed [OFS_W-1:0] sh_off_x = '0;
	logic signed [OFS_W-1:0] sh_off_y = '0;
	logic [DIM_W-1:0]        sh_src_w = DIM_W'(1);
	logic [DIM_W-1:0]        sh_src_h = DIM_W'(1);
	logic [CNT_W-1:0]        src_col = '0;
	logic [CNT_W-1:0]        src_row = '0;

	clipped_xrgb_to_rgb24_blit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_word   (pixel_word),
		.buffer_start (buffer_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_address (byte_address),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int dim_eff(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (int'(v) > MAX_DIMENSION) return MAX_DIMENSION;
		return int'(v);
	endfunction

	function automatic bit gap();
		return !calm && ($urandom_range(0, 99) < 17);
	endfunction

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// Place one pixel in the destination frame and advance the raster position
	task automatic place_pixel(input pixel_t p);
		int   dw, dh, sw, sh, tx, ty;
		rgb_t e;
		dw = dim_eff(sh_dest_w);
		dh = dim_eff(sh_dest_h);
		sw = dim_eff(sh_src_w);
		sh = dim_eff(sh_src_h);
		if (p.start) begin
			src_col = '0;
			src_row = '0;
		end
		tx = int'(sh_off_x) + int'(src_col);
		ty = int'(sh_off_y) + int'(src_row);
		if (tx >= 0 && tx < dw && ty >= 0 && ty < dh) begin
			e.addr = ADDR_W'((ty * dw + tx) * 3);
			e.r = p.word[23:16];
			e.g = p.word[15:8];
			e.b = p.word[7:0];
			expected_rgb.push_back(e);
		end
		if (int'(src_col) + 1 >= sw) begin
			src_col = '0;
			if (int'(src_row) + 1 >= sh) begin
				src_row = '0;
			end else begin
				src_row = src_row + 1'b1;
			end
		end else begin
			src_col = src_col + 1'b1;
		end
	endtask

	always @(posedge clk) begin
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			place_pixel('{word: pixel_word, start: buffer_start});
		end
	end

	always @(posedge clk) begin : result_check
		rgb_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rgb.size() == 0) begin
				report($sformatf("result with none expected, address %0h", byte_address));
			end else begin
				want = expected_rgb.pop_front();
				if (byte_address !== want.addr)
					report($sformatf("byte_address %0h, want %0h", byte_address, want.addr));
				if (red !== want.r)
					report($sformatf("red %0h, want %0h at %0h", red, want.r, want.addr));
				if (green !== want.g)
					report($sformatf("green %0h, want %0h at %0h", green, want.g, want.addr));
				if (blue !== want.b)
					report($sformatf("blue %0h, want %0h at %0h", blue, want.b, want.addr));
			end
		end
	end

	// Hold the pixel until it is taken, then advance to the next pending one
	always @(negedge clk) begin : pixel_driver
		pixel_t cur;
		if (!in_valid || in_fire) begin
			if (arst_n && pending_px.size() != 0 && !gap()) begin
				cur = pending_px.pop_front();
				pixel_word <= cur.word;
				buffer_start <= cur.start;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && gap();
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		unique case (idx)
			REG_DEST_WIDTH:    sh_dest_w = data[DIM_W-1:0];
			REG_DEST_HEIGHT:   sh_dest_h = data[DIM_W-1:0];
			REG_OFFSET_X:      sh_off_x = data[OFS_W-1:0];
			REG_OFFSET_Y:      sh_off_y = data[OFS_W-1:0];
			REG_SOURCE_WIDTH:  sh_src_w = data[DIM_W-1:0];
			REG_SOURCE_HEIGHT: sh_src_h = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_px(input logic [31:0] w, input logic s);
		pending_px.push_back('{word: w, start: s});
	endtask

	// Queue a run of random pixels; mode 0 marks the first, 1 marks at random, 2 never
	task automatic send_run(input int count, input int mode);
		logic s;
		for (int i = 0; i < count; i++) begin
			unique case (mode)
				0: s = (i == 0);
				1: s = ($urandom_range(0, 9) == 0);
				default: s = 1'b0;
			endcase
			push_px($urandom, s);
		end
	endtask

	// Wait for the stream to drain and the pipeline to go quiet
	task automatic settle();
		do @(posedge clk);
		while (pending_px.size() != 0 || in_valid || expected_rgb.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [CFG_W-1:0] pick_dim(input bit src);
		int r, v;
		r = $urandom_range(0, 99);
		if (src) begin
			if (r < 88) v = $urandom_range(1, 10);
			else if (r < 94) v = 0;
			else if (r < 97) v = $urandom_range(11, 300);
			else v = $urandom_range(4097, 8191);
		end else begin
			if (r < 75) v = $urandom_range(1, 24);
			else if (r < 85) v = $urandom_range(1, 4096);
			else if (r < 92) v = 0;
			else v = $urandom_range(4097, 8191);
		end
		return {3'($urandom_range(0, 7)), DIM_W'(v)};
	endfunction

	function automatic logic [CFG_W-1:0] pick_offset(input int dest, input int src);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return CFG_W'(int'($urandom_range(0, dest + src)) - src);
		if (r < 85) return CFG_W'($urandom);
		unique case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'h0000;
		endcase
	endfunction

	initial begin : stimulus
		int phase, rand_items, nbuf, len, r;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults after reset: a 1x1 source placed at the frame origin
		push_px(32'hFFFF_FFFF, 1'b1);
		push_px(32'h0000_0000, 1'b0);
		settle();

		// Bottom right corner of the largest frame, rest clipped
		write_reg(REG_DEST_WIDTH, CFG_W'(4096));
		write_reg(REG_DEST_HEIGHT, CFG_W'(4096));
		write_reg(REG_OFFSET_X, CFG_W'(4095));
		write_reg(REG_OFFSET_Y, CFG_W'(4095));
		write_reg(REG_SOURCE_WIDTH, CFG_W'(2));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(2));
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_HI, 16'h0000);
		push_px(32'h00FF_00FF, 1'b1);
		push_px(32'hFF00_FF00, 1'b0);
		push_px(32'hA5A5_A5A5, 1'b0);
		push_px(32'h5A5A_5A5A, 1'b0);
		settle();

		// Zero sizes read as one; upper data bits of size registers are dropped
		write_reg(REG_DEST_WIDTH, 16'h0000);
		write_reg(REG_DEST_HEIGHT, 16'h0000);
		write_reg(REG_OFFSET_X, 16'hFFFF);
		write_reg(REG_OFFSET_Y, 16'h0000);
		write_reg(REG_SOURCE_WIDTH, 16'hE003);
		write_reg(REG_SOURCE_HEIGHT, 16'hE001);
		push_px(32'h1234_5678, 1'b1);
		push_px(32'h9ABC_DEF0, 1'b0);
		push_px(32'h0F0F_0F0F, 1'b0);
		settle();

		// Oversized dimensions clamp; extreme offsets drop everything
		write_reg(REG_DEST_WIDTH, CFG_W'(8191));
		write_reg(REG_DEST_HEIGHT, CFG_W'(4097));
		write_reg(REG_OFFSET_X, 16'h8000);
		write_reg(REG_OFFSET_Y, 16'h7FFF);
		push_px(32'hDEAD_BEEF, 1'b1);
		push_px(32'hCAFE_F00D, 1'b0);
		settle();

		// Restart mid-buffer, then leave the position at column 2, row 1
		write_reg(REG_OFFSET_X, 16'h0000);
		write_reg(REG_OFFSET_Y, 16'h0000);
		write_reg(REG_SOURCE_WIDTH, CFG_W'(4));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(4));
		send_run(3, 0);
		send_run(6, 0);
		settle();

		// Shrink the source below the current position
		write_reg(REG_SOURCE_WIDTH, CFG_W'(1));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(0));
		send_run(3, 2);
		settle();

		// Full-width source and frame: the first row of a wide buffer
		write_reg(REG_DEST_WIDTH, CFG_W'(4096));
		write_reg(REG_DEST_HEIGHT, CFG_W'(2));
		write_reg(REG_OFFSET_X, CFG_W'(5));
		write_reg(REG_SOURCE_WIDTH, CFG_W'(4096));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(2));
		send_run(40, 0);
		settle();

		// Full-height source: one column walking down a tall frame
		write_reg(REG_DEST_WIDTH, CFG_W'(3));
		write_reg(REG_DEST_HEIGHT, CFG_W'(4096));
		write_reg(REG_OFFSET_X, CFG_W'(1));
		write_reg(REG_OFFSET_Y, CFG_W'(2));
		write_reg(REG_SOURCE_WIDTH, CFG_W'(1));
		write_reg(REG_SOURCE_HEIGHT, CFG_W'(4096));
		send_run(40, 0);
		settle();

		rand_items = 0;
		phase = 0;
		while (rand_items < 1100) begin
			calm = (phase >= 12 && phase < 22);
			if ($urandom_range(0, 9) < 7) write_reg(REG_DEST_WIDTH, pick_dim(1'b0));
			if ($urandom_range(0, 9) < 7) write_reg(REG_DEST_HEIGHT, pick_dim(1'b0));
			if ($urandom_range(0, 9) < 7) write_reg(REG_SOURCE_WIDTH, pick_dim(1'b1));
			if ($urandom_range(0, 9) < 7) write_reg(REG_SOURCE_HEIGHT, pick_dim(1'b1));
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_OFFSET_X, pick_offset(dim_eff(sh_dest_w), dim_eff(sh_src_w)));
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_OFFSET_Y, pick_offset(dim_eff(sh_dest_h), dim_eff(sh_src_h)));
			if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED_HI, CFG_W'($urandom));
			nbuf = $urandom_range(1, 3);
			for (int b = 0; b < nbuf; b++) begin
				len = dim_eff(sh_src_w) * dim_eff(sh_src_h);
				if (len > BUF_CAP) len = $urandom_range(1, BUF_CAP);
				r = $urandom_range(0, 99);
				if (r < 80) begin
					send_run(len, 0);
				end else if (r < 90) begin
					len = $urandom_range(1, len);
					send_run(len, 0);
				end else if (r < 95) begin
					send_run(len, 1);
				end else begin
					send_run(len, 2);
				end
				rand_items += len;
				// Hold the sender until every outstanding result is back
				if (phase == 4 && b == 0) settle();
			end
			settle();
			phase++;
		end
		calm = 1'b0;

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
